FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the timestamp filter RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check on the rising clock, muted while reset is held low.
`define NTDLL_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on the rising clock at every edge, reset included.
`define NTDLL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NTDLL_ASSERT_RST(label, clk, rst_n, prop, msg)
`define NTDLL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/ntdll_pkg.sv
// Package of the timestamp filter: time type, register map, config struct,
// fixed-point constants and saturating add/subtract. No dependencies.
package ntdll_pkg;

    localparam int TIME_W    = 64;
    localparam int PERIOD_W  = 48;
    localparam int COEF_W    = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [TIME_W-1:0] t_time;

    localparam t_time TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
    localparam t_time TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

    localparam logic [COEF_W-1:0] ONE_Q31   = 32'h8000_0000;
    localparam logic [COEF_W-1:0] SQRT2_Q31 = 32'd3037000500;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOMINAL_PERIOD  = 3'd0,
        CFG_OMEGA_SCALE     = 3'd1,
        CFG_START_BANDWIDTH = 3'd2,
        CFG_END_BANDWIDTH   = 3'd3,
        CFG_NARROWING_COEFF = 3'd4
    } t_cfg_idx;

    localparam logic [PERIOD_W-1:0] RST_NOMINAL_PERIOD  = 48'd349525333333;
    localparam logic [COEF_W-1:0]   RST_OMEGA_SCALE     = 32'd143925736;
    localparam logic [COEF_W-1:0]   RST_START_BANDWIDTH = 32'd33554432;
    localparam logic [COEF_W-1:0]   RST_END_BANDWIDTH   = 32'd167772;
    localparam logic [COEF_W-1:0]   RST_NARROWING_COEFF = 32'd2145194216;

    typedef struct packed {
        logic [PERIOD_W-1:0] nominal_period;
        logic [COEF_W-1:0]   omega_scale;
        logic [COEF_W-1:0]   start_bandwidth;
        logic [COEF_W-1:0]   end_bandwidth;
        logic [COEF_W-1:0]   narrowing_coeff;
    } t_cfg;

    function automatic t_time sat_add(input t_time a, input t_time b);
        t_time s;
        s = a + b;
        if ((a[TIME_W-1] == b[TIME_W-1]) && (s[TIME_W-1] != a[TIME_W-1])) begin
            return a[TIME_W-1] ? TIME_MIN : TIME_MAX;
        end
        return s;
    endfunction

    function automatic t_time sat_sub(input t_time a, input t_time b);
        t_time d;
        d = a - b;
        if ((a[TIME_W-1] != b[TIME_W-1]) && (d[TIME_W-1] != a[TIME_W-1])) begin
            return a[TIME_W-1] ? TIME_MIN : TIME_MAX;
        end
        return d;
    endfunction

endpackage

FILE: rtl/core/ntdll_ifs.sv
// Valid/ready channel interfaces of the timestamp filter: input, result
// and register write. Depends on ntdll_pkg.
interface ntdll_in_if;
    logic                  valid;
    logic                  ready;
    ntdll_pkg::t_time      measured_time;

    modport source (output valid, output measured_time, input ready);
    modport sink   (input valid, input measured_time, output ready);
endinterface

interface ntdll_out_if;
    logic                  valid;
    logic                  ready;
    ntdll_pkg::t_time      current_estimate;
    ntdll_pkg::t_time      next_estimate;

    modport source (output valid, output current_estimate, output next_estimate,
                    input ready);
    modport sink   (input valid, input current_estimate, input next_estimate,
                    output ready);
endinterface

interface ntdll_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ntdll_pkg::CFG_IDX_W-1:0]     index;
    logic [ntdll_pkg::PERIOD_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ntdll_cfg_regs.sv
// Register file of the timestamp filter: decode writes, hold settings.
// Depends on ntdll_pkg and ntdll_cfg_if.
module ntdll_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ntdll_cfg_if.sink         i_cfg,
    output ntdll_pkg::t_cfg   o_cfg
);
    import ntdll_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nominal_period  <= RST_NOMINAL_PERIOD;
            r_cfg.omega_scale     <= RST_OMEGA_SCALE;
            r_cfg.start_bandwidth <= RST_START_BANDWIDTH;
            r_cfg.end_bandwidth   <= RST_END_BANDWIDTH;
            r_cfg.narrowing_coeff <= RST_NARROWING_COEFF;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_NOMINAL_PERIOD:  r_cfg.nominal_period  <= i_cfg.data;
                CFG_OMEGA_SCALE:     r_cfg.omega_scale     <= i_cfg.data[COEF_W-1:0];
                CFG_START_BANDWIDTH: r_cfg.start_bandwidth <= i_cfg.data[COEF_W-1:0];
                CFG_END_BANDWIDTH:   r_cfg.end_bandwidth   <= i_cfg.data[COEF_W-1:0];
                CFG_NARROWING_COEFF: r_cfg.narrowing_coeff <= i_cfg.data[COEF_W-1:0];
                default: ; // drop writes to unmapped indexes
            endcase
        end
    end

endmodule

FILE: rtl/core/ntdll_mul.sv
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// Depends on ntdll_pkg for the operand width.
module ntdll_mul (
    input  logic                              i_clk,
    input  logic [ntdll_pkg::COEF_W-1:0]      i_a,
    input  logic [ntdll_pkg::COEF_W-1:0]      i_b,
    output logic [2*ntdll_pkg::COEF_W-1:0]    o_prod
);
    import ntdll_pkg::*;

    logic [2*COEF_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (2*COEF_W)'(i_a) * (2*COEF_W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/core/narrowing_timestamp_dll.sv
// Top level of the narrowing-bandwidth timestamp filter (second-order DLL).
// Depends on ntdll_pkg, ntdll_ifs, ntdll_cfg_regs, ntdll_mul, assert_macros.svh.
//
// Usage:
//   i_in  : request carrying one measured block timestamp, signed Q48.16 ns.
//   o_out : request carrying the filtered current time and the predicted next
//           time, both signed Q48.16 ns and saturated to the 64-bit range.
//   i_cfg : register writes (index, data), always ready; write only while idle.
// Sequence:
//   The first request after reset goes through the seeding step to o_out.valid.
//   Every later request goes to a sequencer that runs nine products
//   (bandwidth narrowing, omega, the two loop gains and the two gain-times-
//   error products split into 32-bit halves) through one shared 32x32
//   multiplier, followed by the saturating time updates. i_in.ready is high
//   only while the sequencer is idle, so a new request is not taken until
//   the last one has been loaded into the output register.
// Stall: the result sits in an output register; the next request is taken
//   and computed while it waits, and its finish step holds until o_out frees.
// Reset: synchronous, active low; the next request is treated as the first.
`include "assert_macros.svh"

module narrowing_timestamp_dll (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ntdll_in_if.sink     i_in,
    ntdll_out_if.source  o_out,
    ntdll_cfg_if.sink    i_cfg
);
    import ntdll_pkg::*;

    localparam logic [2*COEF_W-1:0] RND_Q24 = 64'h0000_0000_0080_0000;
    localparam logic [2*COEF_W-1:0] RND_Q31 = 64'h0000_0000_4000_0000;
    localparam logic [2*COEF_W-1:0] RND_Q32 = 64'h0000_0000_8000_0000;

    typedef enum logic [4:0] {
        S_IDLE, S_FIRST,
        S_BW_A, S_BW_B, S_BW_C,
        S_OM_A, S_OM_B,
        S_B_A, S_C_A, S_C_B,
        S_GB_HI, S_GB_SUM, S_GC_HI, S_GC_SUM,
        S_UPD_A, S_UPD_B,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_first;
    logic   r_out_valid;

    // Payload registers
    t_time               r_meas;
    t_time               r_cur;
    t_time               r_next;
    t_time               r_pred;
    t_time               r_period;
    t_time               r_err;
    t_time               r_gain_b;
    t_time               r_gain_c;
    t_time               r_out_cur;
    t_time               r_out_next;
    logic [TIME_W-1:0]   r_mag;
    logic [TIME_W-1:0]   r_gain;
    logic [2*COEF_W-1:0] r_acc;
    logic [COEF_W-1:0]   r_bw;
    logic [COEF_W-1:0]   r_omega;
    logic [COEF_W-1:0]   r_b;
    logic [COEF_W-1:0]   r_c;
    logic                r_neg;

    t_cfg                cfg;
    logic [COEF_W-1:0]   mul_a;
    logic [COEF_W-1:0]   mul_b;
    logic [2*COEF_W-1:0] prod;

    logic                in_acc;
    logic                out_load;
    logic [COEF_W-1:0]   k_eff;
    logic [COEF_W-1:0]   k_rest;
    logic [2*COEF_W-1:0] bw_sum;
    logic [2*COEF_W-1:0] om_sum;
    logic [2*COEF_W-1:0] b_sum;
    logic [2*COEF_W-1:0] prod_rnd;
    logic [TIME_W-1:0]   gain_sum;
    logic [TIME_W-1:0]   neg_gain;
    logic [COEF_W-1:0]   omega_sat;
    logic [COEF_W-1:0]   b_sat;
    t_time               period_ext;

    ntdll_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ntdll_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_load = !r_out_valid || o_out.ready;

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.current_estimate = r_out_cur;
    assign o_out.next_estimate    = r_out_next;

    // A narrowing factor above one holds the bandwidth.
    assign k_eff  = (cfg.narrowing_coeff > ONE_Q31) ? ONE_Q31 : cfg.narrowing_coeff;
    assign k_rest = ONE_Q31 - k_eff;

    assign bw_sum    = r_acc + prod;
    assign om_sum    = prod + RND_Q24;
    assign omega_sat = (|om_sum[63:56]) ? '1 : om_sum[55:24];
    assign b_sum     = prod + RND_Q31;
    assign b_sat     = b_sum[63] ? '1 : b_sum[62:31];
    assign prod_rnd  = prod + RND_Q32;
    assign gain_sum  = prod + {{COEF_W{1'b0}}, r_acc[63:32]};
    assign neg_gain  = '0 - r_gain;

    assign period_ext = t_time'({{(TIME_W-PERIOD_W){1'b0}}, cfg.nominal_period});

    // Route operands to the shared multiplier; its product is registered.
    always_comb begin
        unique case (r_state)
            S_BW_A:   begin mul_a = r_bw;               mul_b = k_eff;     end
            S_BW_B:   begin mul_a = cfg.end_bandwidth;  mul_b = k_rest;    end
            S_OM_A:   begin mul_a = cfg.omega_scale;    mul_b = r_bw;      end
            S_B_A:    begin mul_a = r_omega;            mul_b = SQRT2_Q31; end
            S_C_A:    begin mul_a = r_omega;            mul_b = r_omega;   end
            S_C_B:    begin mul_a = r_mag[31:0];        mul_b = r_b;       end
            S_GB_HI:  begin mul_a = r_mag[63:32];       mul_b = r_b;       end
            S_GB_SUM: begin mul_a = r_mag[31:0];        mul_b = r_c;       end
            S_GC_HI:  begin mul_a = r_mag[63:32];       mul_b = r_c;       end
            default:  begin mul_a = '0;                 mul_b = '0;        end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FINISH && out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_meas  <= i_in.measured_time;
                        r_state <= r_first ? S_FIRST : S_BW_A;
                    end
                end
                S_FIRST: begin
                    // Seed the loop: take the measurement as is, nominal period.
                    r_bw     <= cfg.start_bandwidth;
                    r_cur    <= r_meas;
                    r_period <= period_ext;
                    r_next   <= sat_add(r_meas, period_ext);
                    r_first  <= 1'b0;
                    r_state  <= S_FINISH;
                end
                S_BW_A: r_state <= S_BW_B;
                S_BW_B: begin
                    r_acc   <= prod + RND_Q31;
                    r_state <= S_BW_C;
                end
                S_BW_C: begin
                    r_bw    <= bw_sum[62:31];
                    r_err   <= sat_sub(r_meas, r_pred);
                    r_cur   <= r_pred;
                    r_state <= S_OM_A;
                end
                S_OM_A: begin
                    // Split the error into sign and magnitude for the gain products.
                    r_neg   <= r_err[TIME_W-1];
                    r_mag   <= r_err[TIME_W-1] ? ('0 - r_err) : r_err;
                    r_state <= S_OM_B;
                end
                S_OM_B: begin
                    r_omega <= omega_sat;
                    r_state <= S_B_A;
                end
                S_B_A: r_state <= S_C_A;
                S_C_A: begin
                    r_b     <= b_sat;
                    r_state <= S_C_B;
                end
                S_C_B: begin
                    r_c     <= prod_rnd[63:32];
                    r_state <= S_GB_HI;
                end
                S_GB_HI: begin
                    r_acc   <= prod_rnd;
                    r_state <= S_GB_SUM;
                end
                S_GB_SUM: begin
                    r_gain  <= gain_sum;
                    r_state <= S_GC_HI;
                end
                S_GC_HI: begin
                    r_acc    <= prod_rnd;
                    r_gain_b <= r_neg ? neg_gain : r_gain;
                    r_state  <= S_GC_SUM;
                end
                S_GC_SUM: begin
                    r_gain  <= gain_sum;
                    r_next  <= sat_add(r_cur, r_gain_b);
                    r_state <= S_UPD_A;
                end
                S_UPD_A: begin
                    r_gain_c <= r_neg ? neg_gain : r_gain;
                    r_next   <= sat_add(r_next, r_period);
                    r_state  <= S_UPD_B;
                end
                S_UPD_B: begin
                    r_period <= sat_add(r_period, r_gain_c);
                    r_state  <= S_FINISH;
                end
                S_FINISH: begin
                    // Hold here until the output register frees.
                    if (out_load) begin
                        r_out_cur  <= r_cur;
                        r_out_next <= r_next;
                        r_pred     <= r_next;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `NTDLL_ASSERT_RST(a_accept_leaves_idle, i_clk, i_rst_n, in_acc |=> (r_state != S_IDLE), "request accepted but sequencer stayed idle")
    `NTDLL_ASSERT_RST(a_first_request_seeds, i_clk, i_rst_n, (in_acc && r_first) |=> (r_state == S_FIRST), "first request did not take the seeding path")
    `NTDLL_ASSERT_RST(a_first_flag_clears, i_clk, i_rst_n, $fell(r_first) |-> ($past(r_state) == S_FIRST), "first flag cleared outside the seeding step")
    `NTDLL_ASSERT_RST(a_finish_delivers, i_clk, i_rst_n, (r_state == S_FINISH && out_load) |=> (o_out.valid && r_state == S_IDLE), "finished result not loaded into the output register")

endmodule
